// File: hw/rtl/xed_pkg.sv
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types, codes and lookup functions of the entity decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xed_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned NumNames   = 5;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_UNTERM    = 3'd1,
        ERR_UNSUP     = 3'd2,
        ERR_EMPTY     = 3'd3,
        ERR_MALFORMED = 3'd4,
        ERR_SURROGATE = 3'd5,
        ERR_TOO_LARGE = 3'd6
    } t_err;

    // one queue entry: everything the back end needs to emit a transaction run
    typedef struct packed {
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      last_idx;  // number of bytes minus one
        logic            text_end;
        t_err            err;
    } t_cmd;

    // character at position pos of named entity idx (amp, lt, gt, quot, apos)
    function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [1:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            3'd0: begin
                case (pos)
                    2'd0:    ch = 8'h61;
                    2'd1:    ch = 8'h6D;
                    2'd2:    ch = 8'h70;
                    default: ch = 8'h00;
                endcase
            end
            3'd1: begin
                case (pos)
                    2'd0:    ch = 8'h6C;
                    2'd1:    ch = 8'h74;
                    default: ch = 8'h00;
                endcase
            end
            3'd2: begin
                case (pos)
                    2'd0:    ch = 8'h67;
                    2'd1:    ch = 8'h74;
                    default: ch = 8'h00;
                endcase
            end
            3'd3: begin
                case (pos)
                    2'd0:    ch = 8'h71;
                    2'd1:    ch = 8'h75;
                    2'd2:    ch = 8'h6F;
                    default: ch = 8'h74;
                endcase
            end
            3'd4: begin
                case (pos)
                    2'd0:    ch = 8'h61;
                    2'd1:    ch = 8'h70;
                    2'd2:    ch = 8'h6F;
                    default: ch = 8'h73;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] name_len(input logic [2:0] idx);
        logic [2:0] len;
        case (idx)
            3'd0:    len = 3'd3;
            3'd1:    len = 3'd2;
            3'd2:    len = 3'd2;
            3'd3:    len = 3'd4;
            3'd4:    len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] name_value(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h26;
            3'd1:    val = 8'h3C;
            3'd2:    val = 8'h3E;
            3'd3:    val = 8'h22;
            3'd4:    val = 8'h27;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/xed_front.sv
// ----------------------------------------------------------------------------
// xed_front
// Input parser: tracks entity state per byte and queues one command for
// every input byte that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module xed_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [7:0]    i_s_tdata,
    input  wire logic          i_s_tlast,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output xed_pkg::t_cmd      o_q_cmd
);

    localparam logic [7:0] ChAmp  = 8'h26;
    localparam logic [7:0] ChSemi = 8'h3B;
    localparam logic [7:0] ChHash = 8'h23;

    logic        r_inside, n_inside;
    logic [2:0]  r_len,    n_len;
    logic [4:0]  r_cand,   n_cand;
    logic        r_hash,   n_hash;
    logic        r_hex,    n_hex;
    logic        r_digits, n_digits;
    logic        r_bad,    n_bad;
    logic [31:0] r_scalar, n_scalar;
    logic        r_ovf,    n_ovf;
    logic        r_drop,   n_drop;

    logic        accept;
    logic [7:0]  c;
    logic [4:0]  digit;
    logic [35:0] scaled;
    logic [35:0] sum;
    xed_pkg::t_err  fin_err;
    logic [3:0][7:0] fin_bytes;
    logic [1:0]  fin_last;
    logic        name_hit;
    logic [7:0]  name_byte;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign c          = i_s_tdata;

    // digit value for the current base, 16 marks a bad digit
    always_comb begin
        digit = 5'd16;
        if (c inside {[8'h30:8'h39]}) begin
            digit = {1'b0, c[3:0]};
        end else if (r_hex && (c inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
            digit = 5'd9 + {2'b00, c[2:0]};
        end
    end

    assign scaled = r_hex ? {r_scalar, 4'b0000}
                          : ({1'b0, r_scalar, 3'b000} + {3'b000, r_scalar, 1'b0});
    assign sum    = scaled + {32'd0, digit[3:0]};

    // decode of the finished body at ';'
    always_comb begin
        fin_err   = xed_pkg::ERR_NONE;
        fin_bytes = '0;
        fin_last  = 2'd0;
        name_hit  = 1'b0;
        name_byte = 8'h00;
        for (int i = 0; i < xed_pkg::NumNames; i++) begin
            if (!name_hit && r_cand[i] && (r_len == xed_pkg::name_len(3'(i)))) begin
                name_hit  = 1'b1;
                name_byte = xed_pkg::name_value(3'(i));
            end
        end
        if (!r_hash) begin
            if (name_hit) begin
                fin_bytes[0] = name_byte;
            end else begin
                fin_err = xed_pkg::ERR_UNSUP;
            end
        end else if (r_len < 3'd2) begin
            fin_err = xed_pkg::ERR_UNSUP;
        end else if (r_bad) begin
            fin_err = xed_pkg::ERR_MALFORMED;
        end else if (!r_digits) begin
            fin_err = xed_pkg::ERR_EMPTY;
        end else if (r_ovf) begin
            fin_err = xed_pkg::ERR_MALFORMED;
        end else if (r_scalar <= 32'h7F) begin
            fin_bytes[0] = r_scalar[7:0];
        end else if (r_scalar <= 32'h7FF) begin
            fin_bytes[0] = 8'hC0 | {3'b000, r_scalar[10:6]};
            fin_bytes[1] = 8'h80 | {2'b00, r_scalar[5:0]};
            fin_last     = 2'd1;
        end else if (r_scalar >= 32'hD800 && r_scalar <= 32'hDFFF) begin
            fin_err = xed_pkg::ERR_SURROGATE;
        end else if (r_scalar <= 32'hFFFF) begin
            fin_bytes[0] = 8'hE0 | {4'b0000, r_scalar[15:12]};
            fin_bytes[1] = 8'h80 | {2'b00, r_scalar[11:6]};
            fin_bytes[2] = 8'h80 | {2'b00, r_scalar[5:0]};
            fin_last     = 2'd2;
        end else if (r_scalar <= 32'h10FFFF) begin
            fin_bytes[0] = 8'hF0 | {5'b00000, r_scalar[20:18]};
            fin_bytes[1] = 8'h80 | {2'b00, r_scalar[17:12]};
            fin_bytes[2] = 8'h80 | {2'b00, r_scalar[11:6]};
            fin_bytes[3] = 8'h80 | {2'b00, r_scalar[5:0]};
            fin_last     = 2'd3;
        end else begin
            fin_err = xed_pkg::ERR_TOO_LARGE;
        end
    end

    always_comb begin
        n_inside = r_inside;
        n_len    = r_len;
        n_cand   = r_cand;
        n_hash   = r_hash;
        n_hex    = r_hex;
        n_digits = r_digits;
        n_bad    = r_bad;
        n_scalar = r_scalar;
        n_ovf    = r_ovf;
        n_drop   = r_drop;
        o_q_push = 1'b0;
        o_q_cmd          = '0;
        o_q_cmd.text_end = i_s_tlast;
        o_q_cmd.err      = xed_pkg::ERR_NONE;

        if (accept) begin
            if (r_drop) begin
                if (i_s_tlast) begin
                    n_drop = 1'b0;
                end
            end else if (!r_inside) begin
                if (c != ChAmp) begin
                    o_q_push         = 1'b1;
                    o_q_cmd.bytes[0] = c;
                end else if (i_s_tlast) begin
                    o_q_push    = 1'b1;
                    o_q_cmd.err = xed_pkg::ERR_UNTERM;
                end else begin
                    n_inside = 1'b1;
                end
            end else if (c != ChSemi) begin
                for (int i = 0; i < xed_pkg::NumNames; i++) begin
                    if ((r_len >= xed_pkg::name_len(3'(i)))
                        || (xed_pkg::name_char(3'(i), r_len[1:0]) != c)) begin
                        n_cand[i] = 1'b0;
                    end
                end
                if (r_len == 3'd0) begin
                    if (c == ChHash) begin
                        n_hash = 1'b1;
                    end
                end else if (r_hash) begin
                    if (r_len == 3'd1 && (c == 8'h78 || c == 8'h58)) begin
                        n_hex = 1'b1;
                    end else if (digit[4]) begin
                        n_bad = 1'b1;
                    end else begin
                        n_scalar = sum[31:0];
                        n_digits = 1'b1;
                        if (sum[35:32] != 4'd0) begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                if (r_len != 3'd7) begin
                    n_len = r_len + 3'd1;
                end
                if (i_s_tlast) begin
                    o_q_push    = 1'b1;
                    o_q_cmd.err = xed_pkg::ERR_UNTERM;
                    n_inside    = 1'b0;
                    n_len       = 3'd0;
                    n_cand      = 5'h1F;
                    n_hash      = 1'b0;
                    n_hex       = 1'b0;
                    n_digits    = 1'b0;
                    n_bad       = 1'b0;
                    n_scalar    = 32'd0;
                    n_ovf       = 1'b0;
                end
            end else begin
                o_q_push = 1'b1;
                n_inside = 1'b0;
                n_len    = 3'd0;
                n_cand   = 5'h1F;
                n_hash   = 1'b0;
                n_hex    = 1'b0;
                n_digits = 1'b0;
                n_bad    = 1'b0;
                n_scalar = 32'd0;
                n_ovf    = 1'b0;
                o_q_cmd.err = fin_err;
                if (fin_err != xed_pkg::ERR_NONE) begin
                    n_drop = !i_s_tlast;
                end else begin
                    o_q_cmd.bytes    = fin_bytes;
                    o_q_cmd.last_idx = fin_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_len    <= 3'd0;
            r_cand   <= 5'h1F;
            r_hash   <= 1'b0;
            r_hex    <= 1'b0;
            r_digits <= 1'b0;
            r_bad    <= 1'b0;
            r_scalar <= 32'd0;
            r_ovf    <= 1'b0;
            r_drop   <= 1'b0;
        end else begin
            r_inside <= n_inside;
            r_len    <= n_len;
            r_cand   <= n_cand;
            r_hash   <= n_hash;
            r_hex    <= n_hex;
            r_digits <= n_digits;
            r_bad    <= n_bad;
            r_scalar <= n_scalar;
            r_ovf    <= n_ovf;
            r_drop   <= n_drop;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xed_queue.sv
// ----------------------------------------------------------------------------
// xed_queue
// Short command queue between the parser and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module xed_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire xed_pkg::t_cmd i_push_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output xed_pkg::t_cmd      o_head,
    output logic               o_empty
);

    localparam int unsigned PtrW = $clog2(xed_pkg::QueueDepth);
    localparam int unsigned CntW = $clog2(xed_pkg::QueueDepth + 1);

    xed_pkg::t_cmd   r_mem [xed_pkg::QueueDepth];
    logic [PtrW-1:0] r_wptr, n_wptr;
    logic [PtrW-1:0] r_rptr, n_rptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(xed_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + PtrW'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + PtrW'(1) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xed_back.sv
// ----------------------------------------------------------------------------
// xed_back
// Byte emitter: walks each queued command and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xed_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire xed_pkg::t_cmd i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tlast,
    output logic [3:0]         o_m_tuser
);

    logic       r_valid, n_valid;
    logic [1:0] r_idx,   n_idx;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_done;
    logic [2:0] r_err;
    logic       load;
    logic       is_last;
    logic       is_err;

    assign load    = !i_empty && (!r_valid || i_m_tready);
    assign is_last = (r_idx == i_head.last_idx);
    assign is_err  = (i_head.err != xed_pkg::ERR_NONE);
    assign o_pop   = load && is_last;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = is_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= is_last;
            r_done <= is_err || (is_last && i_head.text_end);
            r_err  <= 3'(i_head.err);
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = {r_err, r_done};

endmodule

`default_nettype wire

// File: hw/rtl/xml_entity_decoder_utf8_core.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder_utf8_core
// XML character-data entity decoder with UTF-8 output.
//
// Input stream: one text byte per transaction, tlast on the final byte of a
// text. Output stream: one decoded byte per transaction; tlast marks the last
// byte produced by one input byte, tuser carries text_done and an error code.
// Plain bytes take one output transaction; a closing ';' yields one to four
// UTF-8 bytes, emitted one per cycle from the queued command while m_tready
// is high. Each command passes the queue, then its bytes the output register.
// Throughput is one input byte per cycle while output is taken every cycle;
// multi-byte entities hold the emitter while it sends each byte, and the
// 4-entry command queue absorbs that before the input sees backpressure.
// A stalled receiver holds the output register, the queue fills, and then
// s_tready drops until space frees up.
// Reset clears entity state, the drop flag, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_entity_decoder_utf8_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  wire logic       i_s_tlast,   // text_end
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic            o_m_tlast,   // run_last
    output logic [3:0]      o_m_tuser    // [0] text_done, [3:1] err_code
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    xed_pkg::t_cmd q_push_cmd;
    xed_pkg::t_cmd q_head;

    xed_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_push_cmd)
    );

    xed_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_head     (q_head),
        .o_empty    (q_empty)
    );

    xed_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire
